// ===== hw/rtl/swmr_pkg.sv =====
// Shared types, sizes and codes for the sliding window max-range block.
// Used by every module and interface of the block; depends on nothing.
`default_nettype none

package swmr_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int SAMPLE_W   = 32;
    localparam int WLEN_W     = 7;
    localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
    localparam int CNT_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam logic [PADDR_W-3:0] REG_WINDOW_LEN = '0;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [SAMPLE_W-1:0]        spread_t;
    typedef logic [LEN_W-1:0]           len_t;
    typedef logic [CNT_W-1:0]           cnt_t;
    typedef logic [WLEN_W-1:0]          wlen_t;

    typedef struct packed {
        logic shift;
        logic rotate;
    } chain_ctl_t;

    typedef struct packed {
        logic take;
        logic first;
        logic update;
        logic clear;
    } scan_ctl_t;

    // zero means one, anything above the row length means the whole row
    function automatic len_t eff_len(input wlen_t wl);
        len_t r;
        if (wl == '0)
            r = len_t'(1);
        else if (int'(wl) > WINDOW_MAX)
            r = len_t'(WINDOW_MAX);
        else
            r = len_t'(wl);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/swmr_in_if.sv =====
// Input channel: one sample per transaction, with the end-of-set mark.
// Depends on swmr_pkg.
`default_nettype none

interface swmr_in_if;
    logic              valid;
    logic              ready;
    swmr_pkg::sample_t sample;
    logic              last;

    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/swmr_out_if.sv =====
// Result channel: best spread of a data set and the full-window flag.
// Depends on swmr_pkg.
`default_nettype none

interface swmr_out_if;
    logic              valid;
    logic              ready;
    swmr_pkg::spread_t max_spread;
    logic              full_window_seen;

    modport source (output valid, output max_spread, output full_window_seen, input ready);
    modport sink (input valid, input max_spread, input full_window_seen, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sliding_window_max_range_core.sv =====
// Top level of the sliding window max-range block: sequencer, APB register,
// result register. Depends on swmr_pkg, swmr_in_if, swmr_out_if, swmr_chain, swmr_scan.
//
//   channel   dir   transaction carries
//   in_ch     in    sample, last
//   out_ch    out   max_spread, full_window_seen (one per data set)
//   apb       in    window_len write/read at byte address 0
//
// Each sample is shifted into the cell row, then the row is rotated once
// past the max/min tracker (ST_SCAN), then the spread is folded into the
// best value (ST_DONE). No new sample is taken until the last one is done.
// Reset clears control, values_seen and the best spread; cells hold garbage
// until written. A final sample stalls in its last cycle while a previous
// result is still waiting on out_ch.
`default_nettype none

module sliding_window_max_range_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    swmr_in_if.sink                              in_ch,
    swmr_out_if.source                           out_ch,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [swmr_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [swmr_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [swmr_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);

    logic [1:0]         state_reg, state_next;
    swmr_pkg::wlen_t    wlen_reg, wlen_next;
    swmr_pkg::len_t     seen_reg, seen_next, seen_inc;
    swmr_pkg::len_t     len_reg, len_next;
    swmr_pkg::cnt_t     cnt_reg, cnt_next;
    logic               eval_reg, eval_next;
    logic               last_reg, last_next;
    logic               out_valid_reg, out_valid_next;
    swmr_pkg::spread_t  out_spread_reg, out_spread_next;
    logic               out_full_reg, out_full_next;

    logic                 in_fire;
    logic                 out_free;
    logic                 proceed;
    logic                 reg_sel;
    swmr_pkg::len_t       len_in;
    swmr_pkg::chain_ctl_t chain_ctl;
    swmr_pkg::scan_ctl_t  scan_ctl;
    swmr_pkg::sample_t    head;
    swmr_pkg::spread_t    best_upd;

    // APB register
    assign reg_sel = (paddr[swmr_pkg::PADDR_W-1:2] == swmr_pkg::REG_WINDOW_LEN);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? swmr_pkg::APB_DATA_W'(wlen_reg) : '0;

    always_comb
    begin
        wlen_next = wlen_reg;
        if (psel && penable && pwrite && reg_sel)
            wlen_next = pwdata[swmr_pkg::WLEN_W-1:0];
    end

    // handshakes
    assign in_ch.ready  = (state_reg == swmr_pkg::ST_IDLE);
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign proceed      = (state_reg == swmr_pkg::ST_DONE) && (!last_reg || out_free);
    assign len_in       = swmr_pkg::eff_len(wlen_reg);
    assign seen_inc     = (seen_reg == swmr_pkg::len_t'(swmr_pkg::WINDOW_MAX))
                          ? seen_reg : seen_reg + swmr_pkg::len_t'(1);

    assign chain_ctl.shift  = in_fire;
    assign chain_ctl.rotate = (state_reg == swmr_pkg::ST_SCAN);

    assign scan_ctl.take   = (state_reg == swmr_pkg::ST_SCAN) && eval_reg
                             && (swmr_pkg::len_t'(cnt_reg) < len_reg);
    assign scan_ctl.first  = (cnt_reg == '0);
    assign scan_ctl.update = proceed && eval_reg;
    assign scan_ctl.clear  = proceed && last_reg;

    always_comb
    begin
        state_next = state_reg;
        seen_next  = seen_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        eval_next  = eval_reg;
        last_next  = last_reg;
        unique case (state_reg)
            swmr_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    seen_next  = seen_inc;
                    len_next   = len_in;
                    eval_next  = (seen_inc >= len_in);
                    last_next  = in_ch.last;
                    cnt_next   = '0;
                    state_next = swmr_pkg::ST_SCAN;
                end
            end
            swmr_pkg::ST_SCAN:
            begin
                cnt_next = cnt_reg + swmr_pkg::cnt_t'(1);
                if (cnt_reg == swmr_pkg::cnt_t'(swmr_pkg::WINDOW_MAX - 1))
                    state_next = swmr_pkg::ST_DONE;
            end
            swmr_pkg::ST_DONE:
            begin
                if (proceed)
                begin
                    if (last_reg)
                        seen_next = '0;
                    state_next = swmr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swmr_pkg::ST_IDLE;
            end
        endcase
    end

    // result register
    always_comb
    begin
        out_spread_next = out_spread_reg;
        out_full_next   = out_full_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        if (proceed && last_reg)
        begin
            out_spread_next = best_upd;
            out_full_next   = eval_reg;
            out_valid_next  = 1'b1;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.max_spread       = out_spread_reg;
    assign out_ch.full_window_seen = out_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swmr_pkg::ST_IDLE;
            wlen_reg      <= swmr_pkg::wlen_t'(1);
            seen_reg      <= '0;
            len_reg       <= swmr_pkg::len_t'(1);
            cnt_reg       <= '0;
            eval_reg      <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wlen_reg      <= wlen_next;
            seen_reg      <= seen_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            eval_reg      <= eval_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_spread_reg <= out_spread_next;
        out_full_reg   <= out_full_next;
    end

    swmr_chain u_chain (
        .clk    (clk),
        .ctl    (chain_ctl),
        .sample (in_ch.sample),
        .head   (head)
    );

    swmr_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (scan_ctl),
        .head     (head),
        .best_upd (best_upd)
    );

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == swmr_pkg::ST_DONE && last_reg))
        else $error("result raised outside end of data set");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(seen_reg) <= swmr_pkg::WINDOW_MAX)
        else $error("values_seen beyond row length");

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == swmr_pkg::ST_SCAN && cnt_reg == '0))
        else $error("accepted sample did not start a scan");

    a_set_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (proceed && last_reg) |=> (seen_reg == '0 && state_reg == swmr_pkg::ST_IDLE))
        else $error("data set state not cleared after result");

endmodule

`default_nettype wire

// ===== hw/rtl/swmr_cell.sv =====
// One window cell: holds a sample, takes its left neighbor on a shift and
// its right neighbor on a rotate. Depends on swmr_pkg.
`default_nettype none

module swmr_cell (
    input  wire logic                 clk,
    input  swmr_pkg::chain_ctl_t      ctl,
    input  swmr_pkg::sample_t         left_in,
    input  swmr_pkg::sample_t         right_in,
    output swmr_pkg::sample_t         value
);

    swmr_pkg::sample_t value_reg;
    swmr_pkg::sample_t value_next;

    always_comb
    begin
        priority if (ctl.shift)
            value_next = left_in;
        else if (ctl.rotate)
            value_next = right_in;
        else
            value_next = value_reg;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/swmr_chain.sv =====
// Row of window cells. Shift brings a new sample into cell 0; rotate moves
// every cell one place toward cell 0, wrapping cell 0 to the far end.
// Depends on swmr_pkg and swmr_cell.
`default_nettype none

module swmr_chain (
    input  wire logic            clk,
    input  swmr_pkg::chain_ctl_t ctl,
    input  swmr_pkg::sample_t    sample,
    output swmr_pkg::sample_t    head
);

    swmr_pkg::sample_t cell_value [swmr_pkg::WINDOW_MAX];

    for (genvar i = 0; i < swmr_pkg::WINDOW_MAX; i++)
    begin : g_cell
        swmr_pkg::sample_t left_in;
        swmr_pkg::sample_t right_in;

        if (i == 0)
        begin : g_first
            assign left_in = sample;
        end
        else
        begin : g_inner_l
            assign left_in = cell_value[i-1];
        end

        if (i == swmr_pkg::WINDOW_MAX - 1)
        begin : g_last
            assign right_in = cell_value[0];
        end
        else
        begin : g_inner_r
            assign right_in = cell_value[i+1];
        end

        swmr_cell u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .left_in  (left_in),
            .right_in (right_in),
            .value    (cell_value[i])
        );
    end

    assign head = cell_value[0];

endmodule

`default_nettype wire

// ===== hw/rtl/swmr_scan.sv =====
// Window max/min tracker fed from the head of the cell row, and the best
// spread of the current data set. Depends on swmr_pkg.
`default_nettype none

module swmr_scan (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  swmr_pkg::scan_ctl_t ctl,
    input  swmr_pkg::sample_t   head,
    output swmr_pkg::spread_t   best_upd
);

    swmr_pkg::sample_t max_reg, max_next;
    swmr_pkg::sample_t min_reg, min_next;
    swmr_pkg::spread_t best_reg, best_next;

    logic signed [swmr_pkg::SAMPLE_W:0] diff;
    swmr_pkg::spread_t                  spread;

    always_comb
    begin
        max_next = max_reg;
        min_next = min_reg;
        if (ctl.take)
        begin
            if (ctl.first || head > max_reg)
                max_next = head;
            if (ctl.first || head < min_reg)
                min_next = head;
        end
    end

    // max - min never exceeds the unsigned sample range
    assign diff   = (swmr_pkg::SAMPLE_W+1)'(max_reg) - (swmr_pkg::SAMPLE_W+1)'(min_reg);
    assign spread = diff[swmr_pkg::SAMPLE_W-1:0];

    assign best_upd = (ctl.update && spread > best_reg) ? spread : best_reg;

    always_comb
    begin
        best_next = ctl.clear ? '0 : best_upd;
    end

    always_ff @(posedge clk)
    begin
        max_reg <= max_next;
        min_reg <= min_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            best_reg <= '0;
        else
            best_reg <= best_next;
    end

endmodule

`default_nettype wire

// ===== test/sliding_window_max_range_core_tb.sv =====
// Self-checking testbench for sliding_window_max_range_core: streams data sets,
// predicts each set's best window spread and checks it. Depends on swmr_pkg,
// swmr_in_if, swmr_out_if and the core itself.
`default_nettype none

module sliding_window_max_range_core_tb;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = swmr_pkg::WINDOW_MAX + 16;
    localparam int DRAIN_CYCLES   = 20000;
    localparam int TIMEOUT_CYCLES = 800000;
    localparam int PHASE_ITEMS    = 115;

    localparam logic [swmr_pkg::PADDR_W-1:0] WLEN_ADDR   = {swmr_pkg::REG_WINDOW_LEN, 2'b00};
    localparam logic [swmr_pkg::PADDR_W-1:0] UNUSED_ADDR = {~swmr_pkg::REG_WINDOW_LEN, 2'b00};

    localparam swmr_pkg::sample_t SAMPLE_MIN = {1'b1, {(swmr_pkg::SAMPLE_W-1){1'b0}}};
    localparam swmr_pkg::sample_t SAMPLE_MAX = {1'b0, {(swmr_pkg::SAMPLE_W-1){1'b1}}};

    typedef enum int {SRC_FULL, SRC_NARROW, SRC_EXTREME} sample_src_t;

    typedef struct {
        swmr_pkg::spread_t spread;
        logic              full;
    } set_result_t;

    logic clk;
    logic rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [swmr_pkg::PADDR_W-1:0]    paddr;
    logic [swmr_pkg::APB_DATA_W-1:0] pwdata;
    logic [swmr_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    swmr_in_if  in_ch ();
    swmr_out_if out_ch ();

    sliding_window_max_range_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    swmr_pkg::sample_t win_row [swmr_pkg::WINDOW_MAX];
    int                seen_cnt;
    swmr_pkg::spread_t best_gap;
    swmr_pkg::wlen_t   len_reg;
    set_result_t       pending_results [$];

    int err_count;
    int samples_sent;
    int sets_checked;
    int in_gap_pct;
    int out_stall_pct;

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= out_stall_pct);

    task automatic flag_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        err_count++;
    endtask

    function automatic int active_len();
        int l;
        l = int'(len_reg);
        if (l == 0)
            l = 1;
        else if (l > swmr_pkg::WINDOW_MAX)
            l = swmr_pkg::WINDOW_MAX;
        return l;
    endfunction

    // shift in one sample, fold the newest window into the best spread
    function automatic void track_sample(input swmr_pkg::sample_t s, input logic lst);
        int                l;
        int                i;
        longint            hi;
        longint            lo;
        swmr_pkg::spread_t gap;
        set_result_t       rec;
        l = active_len();
        for (i = swmr_pkg::WINDOW_MAX - 1; i > 0; i--)
            win_row[i] = win_row[i-1];
        win_row[0] = s;
        if (seen_cnt < swmr_pkg::WINDOW_MAX)
            seen_cnt++;
        if (seen_cnt >= l) begin
            hi = longint'(win_row[0]);
            lo = hi;
            for (i = 1; i < l; i++) begin
                if (longint'(win_row[i]) > hi)
                    hi = longint'(win_row[i]);
                if (longint'(win_row[i]) < lo)
                    lo = longint'(win_row[i]);
            end
            gap = swmr_pkg::spread_t'(hi - lo);
            if (gap > best_gap)
                best_gap = gap;
        end
        if (lst) begin
            rec.spread = best_gap;
            rec.full   = (seen_cnt >= l);
            pending_results.insert(pending_results.size(), rec);
            for (i = 0; i < swmr_pkg::WINDOW_MAX; i++)
                win_row[i] = '0;
            seen_cnt = 0;
            best_gap = '0;
        end
    endfunction

    always @(posedge clk) begin
        set_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result spread=%h full=%b",
                                        out_ch.max_spread, out_ch.full_window_seen));
            end
            else begin
                want = pending_results.pop_front();
                sets_checked++;
                if (out_ch.max_spread !== want.spread)
                    flag_mismatch($sformatf("max_spread got %h want %h",
                                            out_ch.max_spread, want.spread));
                if (out_ch.full_window_seen !== want.full)
                    flag_mismatch($sformatf("full_window_seen got %b want %b",
                                            out_ch.full_window_seen, want.full));
            end
        end
    end

    // one input transaction; valid stays high across back-to-back sends
    task automatic send_sample(input swmr_pkg::sample_t s, input logic lst);
        if ($urandom_range(99) < in_gap_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.sample <= s;
        in_ch.last   <= lst;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        track_sample(s, lst);
        samples_sent++;
    endtask

    // all results in, then room for a sample still in the cell row
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [swmr_pkg::PADDR_W-1:0] addr,
                             input logic [swmr_pkg::APB_DATA_W-1:0] data);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == WLEN_ADDR)
            len_reg = swmr_pkg::wlen_t'(data);
    endtask

    function automatic swmr_pkg::sample_t pick_sample(input sample_src_t src);
        swmr_pkg::sample_t v;
        case (src)
            SRC_FULL:    v = swmr_pkg::sample_t'($urandom);
            SRC_NARROW:  v = swmr_pkg::sample_t'($urandom_range(200)) - swmr_pkg::sample_t'(100);
            default:     v = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
        endcase
        return v;
    endfunction

    task automatic test_reset_length();
        // length 1 out of reset: every window has zero spread
        send_sample(swmr_pkg::sample_t'(5), 1'b0);
        send_sample(-swmr_pkg::sample_t'(3), 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
    endtask

    task automatic test_extremes();
        apb_write(WLEN_ADDR, swmr_pkg::APB_DATA_W'(2));
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(swmr_pkg::sample_t'(-1), 1'b0);
        send_sample(swmr_pkg::sample_t'(0), 1'b1);
    endtask

    task automatic test_short_set();
        send_sample(SAMPLE_MAX, 1'b1);
    endtask

    task automatic test_zero_length();
        apb_write(WLEN_ADDR, swmr_pkg::APB_DATA_W'(0));
        send_sample(swmr_pkg::sample_t'(7), 1'b0);
        send_sample(swmr_pkg::sample_t'(9), 1'b1);
    endtask

    task automatic test_clamped_length();
        apb_write(WLEN_ADDR, swmr_pkg::APB_DATA_W'(100));
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(swmr_pkg::sample_t'(1), 1'b1);
    endtask

    task automatic test_unmapped_register();
        apb_write(UNUSED_ADDR, swmr_pkg::APB_DATA_W'(3));
        send_sample(swmr_pkg::sample_t'(4), 1'b0);
        send_sample(swmr_pkg::sample_t'(-4), 1'b1);
    endtask

    task automatic test_length_change_mid_set();
        apb_write(WLEN_ADDR, swmr_pkg::APB_DATA_W'(3));
        send_sample(swmr_pkg::sample_t'(10), 1'b0);
        send_sample(swmr_pkg::sample_t'(-10), 1'b0);
        apb_write(WLEN_ADDR, swmr_pkg::APB_DATA_W'(2));
        send_sample(swmr_pkg::sample_t'(50), 1'b1);
        apb_write(WLEN_ADDR, swmr_pkg::APB_DATA_W'(swmr_pkg::WLEN_W'(127)));
        send_sample(swmr_pkg::sample_t'(2), 1'b0);
        apb_write(WLEN_ADDR, swmr_pkg::APB_DATA_W'(1));
        send_sample(swmr_pkg::sample_t'(-2), 1'b1);
    endtask

    task automatic test_random_sets(input int wl, input int gap_pct, input int stall_pct);
        int          start;
        int          n;
        int          k;
        sample_src_t src;
        apb_write(WLEN_ADDR, swmr_pkg::APB_DATA_W'(wl));
        in_gap_pct    = gap_pct;
        out_stall_pct = stall_pct;
        start = samples_sent;
        while (samples_sent - start < PHASE_ITEMS) begin
            n = $urandom_range(1, 2 * active_len() + 3);
            src = sample_src_t'($urandom_range(2));
            for (k = 0; k < n; k++) begin
                // extreme sets still get some ordinary values mixed in
                if (src == SRC_EXTREME && $urandom_range(1))
                    send_sample(pick_sample(SRC_FULL), k == n - 1);
                else
                    send_sample(pick_sample(src), k == n - 1);
            end
        end
    endtask

    initial begin
        int waited;
        err_count     = 0;
        samples_sent  = 0;
        sets_checked  = 0;
        in_gap_pct    = 0;
        out_stall_pct = 0;
        seen_cnt      = 0;
        best_gap      = '0;
        len_reg       = swmr_pkg::wlen_t'(1);
        for (int i = 0; i < swmr_pkg::WINDOW_MAX; i++)
            win_row[i] = '0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_ch.valid   = 1'b0;
        in_ch.sample  = '0;
        in_ch.last    = 1'b0;
        out_ch.ready  = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_length();
        test_extremes();
        test_short_set();
        test_zero_length();
        test_clamped_length();
        test_unmapped_register();
        test_length_change_mid_set();

        test_random_sets(1, 0, 0);
        test_random_sets(3, 62, 0);
        test_random_sets(swmr_pkg::WINDOW_MAX, 0, 62);
        test_random_sets($urandom_range(2, 16), 14, 14);
        test_random_sets(0, 0, 0);
        test_random_sets(127, 62, 0);
        test_random_sets($urandom_range(1, swmr_pkg::WINDOW_MAX), 0, 62);
        test_random_sets(8, 14, 14);

        in_ch.valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_CYCLES) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("Covered %0d samples in %0d checked data sets, window lengths 0..127,",
                 samples_sent, sets_checked);
        $display("with free-running, sender-gapped, receiver-stalled and mixed flow control.");
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
